FILE: rtl/ryc_pkg.sv
// Shared types, constants and coefficient table for the RGB to YCbCr converter.
`default_nettype none

package ryc_pkg;

  localparam int MAX_WIDTH  = 4096;
  localparam int MAX_HEIGHT = 4096;

  localparam int DIM_W  = 13;
  localparam int COL_W  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int ROW_W  = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int WCMP_W = (DIM_W > COL_W + 1) ? DIM_W : COL_W + 1;
  localparam int HCMP_W = (DIM_W > ROW_W + 1) ? DIM_W : ROW_W + 1;

  localparam int LINE_DEPTH = (MAX_WIDTH + 1) / 2;
  localparam int LINE_AW    = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
  localparam int SUM_W      = 9;
  localparam int LINE_W     = 3 * SUM_W;
  localparam int TOT_W      = SUM_W + 1;

  localparam int COEF_W = 17;
  localparam int PROD_W = 28;
  localparam int ACC_W  = 32;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = DIM_W;

  localparam logic signed [ACC_W-1:0] Y_ROUND      = 32'sd32768;
  localparam logic signed [ACC_W-1:0] Y_STUDIO_OFS = 32'sd1048576;
  localparam logic signed [ACC_W-1:0] C_BIAS       = 32'sd8421376;

  localparam logic [1:0] STD_BT601  = 2'd0;
  localparam logic [1:0] STD_BT709  = 2'd1;
  localparam logic [1:0] STD_BT2020 = 2'd2;

  localparam logic CHROMA_444 = 1'b0;
  localparam logic CHROMA_420 = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_COLOR_STANDARD = 3'd0,
    REG_STUDIO_RANGE   = 3'd1,
    REG_CHROMA_MODE    = 3'd2,
    REG_FRAME_WIDTH    = 3'd3,
    REG_FRAME_HEIGHT   = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic [1:0]       color_standard;
    logic             studio_range;
    logic             chroma_mode;
    logic [DIM_W-1:0] frame_width;
    logic [DIM_W-1:0] frame_height;
  } cfg_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pix_t;

  typedef struct packed {
    pix_t             pix;
    logic [SUM_W-1:0] sum_r;
    logic [SUM_W-1:0] sum_g;
    logic [SUM_W-1:0] sum_b;
    logic             cvalid;
    logic             use_line;
    logic [1:0]       lg;
    logic             flast;
  } s1_t;

  typedef struct packed {
    pix_t             pix;
    logic [TOT_W-1:0] tot_r;
    logic [TOT_W-1:0] tot_g;
    logic [TOT_W-1:0] tot_b;
    logic             cvalid;
    logic [1:0]       lg;
    logic             flast;
  } s2_t;

  typedef struct packed {
    logic [7:0] luma;
    logic       chroma_valid;
    logic [7:0] blue_diff;
    logic [7:0] red_diff;
    logic       frame_last;
  } res_t;

  typedef struct packed {
    logic signed [COEF_W-1:0] yr;
    logic signed [COEF_W-1:0] yg;
    logic signed [COEF_W-1:0] yb;
    logic signed [COEF_W-1:0] cbr;
    logic signed [COEF_W-1:0] cbg;
    logic signed [COEF_W-1:0] cbb;
    logic signed [COEF_W-1:0] crr;
    logic signed [COEF_W-1:0] crg;
    logic signed [COEF_W-1:0] crb;
  } coef_set_t;

  // Reserved standard code falls back to BT.601.
  function automatic coef_set_t coef_lookup(input logic [1:0] std, input logic studio);
    coef_set_t c;
    unique case (std)
      STD_BT709: begin
        if (studio) begin
          c = '{17'sd11966, 17'sd40254, 17'sd4064, -17'sd6596, -17'sd22188, 17'sd28784,
                17'sd28784, -17'sd26145, -17'sd2639};
        end else begin
          c = '{17'sd13933, 17'sd46871, 17'sd4732, -17'sd7509, -17'sd25259, 17'sd32768,
                17'sd32768, -17'sd29763, -17'sd3005};
        end
      end
      STD_BT2020: begin
        if (studio) begin
          c = '{17'sd14786, 17'sd38160, 17'sd3340, -17'sd8038, -17'sd20746, 17'sd28784,
                17'sd28784, -17'sd26469, -17'sd2315};
        end else begin
          c = '{17'sd17216, 17'sd44433, 17'sd3887, -17'sd9151, -17'sd23617, 17'sd32768,
                17'sd32768, -17'sd30133, -17'sd2635};
        end
      end
      default: begin
        if (studio) begin
          c = '{17'sd16829, 17'sd33039, 17'sd6416, -17'sd9714, -17'sd19070, 17'sd28784,
                17'sd28784, -17'sd24103, -17'sd4681};
        end else begin
          c = '{17'sd19595, 17'sd38470, 17'sd7471, -17'sd11058, -17'sd21710, 17'sd32768,
                17'sd32768, -17'sd27439, -17'sd5329};
        end
      end
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/ryc_rgb_if.sv
// RGB pixel channel with valid/ready handshake.
`default_nettype none

interface ryc_rgb_if;
  logic       valid;
  logic       ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;

  modport source (output valid, output red, output green, output blue, input ready);
  modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

`default_nettype wire

FILE: rtl/ryc_ycc_if.sv
// YCbCr result channel with valid/ready handshake.
`default_nettype none

interface ryc_ycc_if;
  logic       valid;
  logic       ready;
  logic [7:0] luma;
  logic       chroma_valid;
  logic [7:0] blue_diff;
  logic [7:0] red_diff;
  logic       frame_last;

  modport source (output valid, output luma, output chroma_valid, output blue_diff,
                  output red_diff, output frame_last, input ready);
  modport sink   (input valid, input luma, input chroma_valid, input blue_diff,
                  input red_diff, input frame_last, output ready);
endinterface

`default_nettype wire

FILE: rtl/ryc_ram.sv
// Generic single-clock RAM, one write and one registered read port.
`default_nettype none

module ryc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                          clk,
  input  wire logic                                          we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  waddr,
  input  wire logic [WIDTH-1:0]                              wdata,
  input  wire logic                                          re,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  raddr,
  output      logic [WIDTH-1:0]                              rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

FILE: rtl/ryc_front.sv
// Raster counters, pixel pairing and chroma line store with its read stage.
`default_nettype none

module ryc_front (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire ryc_pkg::cfg_t  cfg,
  input  wire logic           in_valid,
  input  wire ryc_pkg::pix_t  in_pix,
  output      logic           in_ready,
  output      logic           out_valid,
  output      ryc_pkg::s2_t   out_data,
  input  wire logic           out_take
);

  localparam int COL_W  = ryc_pkg::COL_W;
  localparam int ROW_W  = ryc_pkg::ROW_W;
  localparam int WCMP_W = ryc_pkg::WCMP_W;
  localparam int HCMP_W = ryc_pkg::HCMP_W;
  localparam int SUM_W  = ryc_pkg::SUM_W;
  localparam int TOT_W  = ryc_pkg::TOT_W;
  localparam int AW     = ryc_pkg::LINE_AW;

  logic [COL_W-1:0]  column_count;
  logic [ROW_W-1:0]  row_count;
  ryc_pkg::pix_t     held_pixel;

  logic              v1;
  ryc_pkg::s1_t      s1;
  ryc_pkg::s1_t      s1_next;
  logic              v2;
  ryc_pkg::s2_t      s2;

  logic              accept;
  logic              adv2;
  logic [WCMP_W-1:0] w_eff;
  logic [HCMP_W-1:0] h_eff;
  logic              last_col;
  logic              bottom_row;
  logic              odd_col;
  logic              odd_row;
  logic              mode420;
  logic              hold;
  logic              pair;
  logic              line_we;
  logic [AW-1:0]     line_addr;
  logic [ryc_pkg::LINE_W-1:0] line_rdata;

  assign adv2     = !v2 || out_take;
  assign in_ready = !v1 || adv2;
  assign accept   = in_valid && in_ready;

  // Clamp the frame size to 1..max.
  always_comb begin
    if (cfg.frame_width == '0) begin
      w_eff = WCMP_W'(1);
    end else if (WCMP_W'(cfg.frame_width) > WCMP_W'(ryc_pkg::MAX_WIDTH)) begin
      w_eff = WCMP_W'(ryc_pkg::MAX_WIDTH);
    end else begin
      w_eff = WCMP_W'(cfg.frame_width);
    end
    if (cfg.frame_height == '0) begin
      h_eff = HCMP_W'(1);
    end else if (HCMP_W'(cfg.frame_height) > HCMP_W'(ryc_pkg::MAX_HEIGHT)) begin
      h_eff = HCMP_W'(ryc_pkg::MAX_HEIGHT);
    end else begin
      h_eff = HCMP_W'(cfg.frame_height);
    end
  end

  assign last_col   = (WCMP_W'(column_count) + WCMP_W'(1)) >= w_eff;
  assign bottom_row = (HCMP_W'(row_count) + HCMP_W'(1)) >= h_eff;
  assign odd_col    = column_count[0];
  assign odd_row    = row_count[0];
  assign mode420    = (cfg.chroma_mode == ryc_pkg::CHROMA_420);
  assign hold       = mode420 && !odd_col && !last_col;
  assign pair       = mode420 && odd_col;
  assign line_addr  = AW'(column_count >> 1);
  assign line_we    = accept && mode420 && !hold && !odd_row && !bottom_row;

  always_comb begin
    s1_next.pix   = in_pix;
    s1_next.sum_r = SUM_W'(in_pix.red)   + (pair ? SUM_W'(held_pixel.red)   : '0);
    s1_next.sum_g = SUM_W'(in_pix.green) + (pair ? SUM_W'(held_pixel.green) : '0);
    s1_next.sum_b = SUM_W'(in_pix.blue)  + (pair ? SUM_W'(held_pixel.blue)  : '0);
    s1_next.flast = last_col && bottom_row;
    s1_next.use_line = 1'b0;
    s1_next.cvalid   = 1'b0;
    s1_next.lg       = 2'd0;
    if (!mode420) begin
      s1_next.cvalid = 1'b1;
    end else if (!hold) begin
      if (odd_row) begin
        s1_next.cvalid   = 1'b1;
        s1_next.use_line = 1'b1;
        s1_next.lg       = {1'b0, odd_col} + 2'd1;
      end else if (bottom_row) begin
        s1_next.cvalid = 1'b1;
        s1_next.lg     = {1'b0, odd_col};
      end
    end
  end

  ryc_ram #(
    .WIDTH (ryc_pkg::LINE_W),
    .DEPTH (ryc_pkg::LINE_DEPTH)
  ) u_line (
    .clk   (clk),
    .we    (line_we),
    .waddr (line_addr),
    .wdata ({s1_next.sum_r, s1_next.sum_g, s1_next.sum_b}),
    .re    (accept),
    .raddr (line_addr),
    .rdata (line_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
      held_pixel   <= '0;
      v1           <= 1'b0;
      v2           <= 1'b0;
    end else begin
      if (accept) begin
        if (last_col) begin
          column_count <= '0;
          row_count    <= bottom_row ? '0 : row_count + ROW_W'(1);
        end else begin
          column_count <= column_count + COL_W'(1);
        end
        if (hold) begin
          held_pixel <= in_pix;
        end
      end
      if (in_ready) begin
        v1 <= in_valid;
      end
      if (adv2) begin
        v2 <= v1;
      end
    end
  end

  // Line read data belongs to the item in stage 1; add it on the way to stage 2.
  always_ff @(posedge clk) begin
    if (accept) begin
      s1 <= s1_next;
    end
    if (adv2 && v1) begin
      s2.pix    <= s1.pix;
      s2.cvalid <= s1.cvalid;
      s2.lg     <= s1.lg;
      s2.flast  <= s1.flast;
      s2.tot_r  <= TOT_W'(s1.sum_r) +
                   (s1.use_line ? TOT_W'(line_rdata[3*SUM_W-1:2*SUM_W]) : '0);
      s2.tot_g  <= TOT_W'(s1.sum_g) +
                   (s1.use_line ? TOT_W'(line_rdata[2*SUM_W-1:SUM_W]) : '0);
      s2.tot_b  <= TOT_W'(s1.sum_b) +
                   (s1.use_line ? TOT_W'(line_rdata[SUM_W-1:0]) : '0);
    end
  end

  assign out_valid = v2;
  assign out_data  = s2;

endmodule

`default_nettype wire

FILE: rtl/ryc_matrix.sv
// Colour matrix: products, rounding, shift and clamp into the result register.
`default_nettype none

module ryc_matrix (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire ryc_pkg::cfg_t  cfg,
  input  wire logic           in_valid,
  input  wire ryc_pkg::s2_t   in_data,
  output      logic           in_take,
  output      logic           out_valid,
  output      ryc_pkg::res_t  out_data,
  input  wire logic           out_ready
);

  localparam int PROD_W = ryc_pkg::PROD_W;
  localparam int ACC_W  = ryc_pkg::ACC_W;
  localparam int TOT_W  = ryc_pkg::TOT_W;

  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [ACC_W-1:0]  acc_t;

  function automatic prod_t mul(input logic [TOT_W-1:0] a,
                                input logic signed [ryc_pkg::COEF_W-1:0] c);
    prod_t ax;
    prod_t cx;
    ax = PROD_W'($signed({1'b0, a}));
    cx = PROD_W'(c);
    return ax * cx;
  endfunction

  // Floor shift by 16 + lg, then clamp to 0..255.
  function automatic logic [7:0] sat8(input acc_t v, input logic [1:0] lg);
    logic [ACC_W-1:0] sh;
    unique case (lg)
      2'd1:    sh = v >> 17;
      2'd2:    sh = v >> 18;
      default: sh = v >> 16;
    endcase
    if (v < 0) begin
      return 8'd0;
    end else if (sh > ACC_W'(255)) begin
      return 8'd255;
    end else begin
      return sh[7:0];
    end
  endfunction

  ryc_pkg::coef_set_t coef;

  logic       v3;
  logic       ov;
  logic       adv_out;
  prod_t      p_yr, p_yg, p_yb;
  prod_t      p_cbr, p_cbg, p_cbb;
  prod_t      p_crr, p_crg, p_crb;
  logic       cvalid3;
  logic [1:0] lg3;
  logic       flast3;
  acc_t       acc_y;
  acc_t       acc_cb;
  acc_t       acc_cr;
  acc_t       y_add;
  acc_t       c_add;
  ryc_pkg::res_t res;

  assign coef    = ryc_pkg::coef_lookup(cfg.color_standard, cfg.studio_range);
  assign adv_out = !ov || out_ready;
  assign in_take = !v3 || adv_out;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
      ov <= 1'b0;
    end else begin
      if (in_take) begin
        v3 <= in_valid;
      end
      if (adv_out) begin
        ov <= v3;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take && in_valid) begin
      p_yr    <= mul(TOT_W'(in_data.pix.red),   coef.yr);
      p_yg    <= mul(TOT_W'(in_data.pix.green), coef.yg);
      p_yb    <= mul(TOT_W'(in_data.pix.blue),  coef.yb);
      p_cbr   <= mul(in_data.tot_r, coef.cbr);
      p_cbg   <= mul(in_data.tot_g, coef.cbg);
      p_cbb   <= mul(in_data.tot_b, coef.cbb);
      p_crr   <= mul(in_data.tot_r, coef.crr);
      p_crg   <= mul(in_data.tot_g, coef.crg);
      p_crb   <= mul(in_data.tot_b, coef.crb);
      cvalid3 <= in_data.cvalid;
      lg3     <= in_data.lg;
      flast3  <= in_data.flast;
    end
  end

  always_comb begin
    y_add  = cfg.studio_range ? (ryc_pkg::Y_STUDIO_OFS + ryc_pkg::Y_ROUND) : ryc_pkg::Y_ROUND;
    c_add  = ryc_pkg::C_BIAS <<< lg3;
    acc_y  = ACC_W'(p_yr) + ACC_W'(p_yg) + ACC_W'(p_yb) + y_add;
    acc_cb = ACC_W'(p_cbr) + ACC_W'(p_cbg) + ACC_W'(p_cbb) + c_add;
    acc_cr = ACC_W'(p_crr) + ACC_W'(p_crg) + ACC_W'(p_crb) + c_add;
    res.luma         = sat8(acc_y, 2'd0);
    res.chroma_valid = cvalid3;
    res.blue_diff    = cvalid3 ? sat8(acc_cb, lg3) : 8'd0;
    res.red_diff     = cvalid3 ? sat8(acc_cr, lg3) : 8'd0;
    res.frame_last   = flast3;
  end

  always_ff @(posedge clk) begin
    if (adv_out && v3) begin
      out_data <= res;
    end
  end

  assign out_valid = ov;

endmodule

`default_nettype wire

FILE: rtl/rgb_to_ycbcr_subsampling_converter.sv
// Streaming RGB to YCbCr converter with optional 4:2:0 chroma subsampling.
//
// pix_in takes one RGB pixel per transfer in raster order; ycc_out gives one
// result per pixel, in order. Every result carries luma; chroma_valid marks
// results that also carry Cb/Cr (every pixel in 4:4:4, the last pixel of each
// 2x2, 2x1, 1x2 or 1x1 block in 4:2:0). frame_last flags the frame's final pixel.
// Throughput is one pixel per cycle while ycc_out.ready is high: the line
// store is a single RAM with one write and one read port, each used at most
// once per pixel. A result passes through four registers: line read, chroma
// sum, multiply, and round and clamp into the output register.
// The cfg port writes a register by index on any cycle with cfg_write high;
// change settings only while no pixel is in flight.
// Reset clears the counters, the held pixel and the pipeline valids, and loads
// the default settings; the line RAM needs no clearing pass.
// A stalled receiver holds the output register; the earlier stages keep
// filling until each is occupied, then pix_in.ready drops.
`default_nettype none

module rgb_to_ycbcr_subsampling_converter (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              cfg_write,
  input  wire logic [ryc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [ryc_pkg::CFG_DATA_W-1:0]    cfg_data,
  ryc_rgb_if.sink                                pix_in,
  ryc_ycc_if.source                              ycc_out
);

  ryc_pkg::cfg_t cfg;
  ryc_pkg::pix_t in_pix;
  ryc_pkg::s2_t  s2_data;
  ryc_pkg::res_t res;
  logic          s2_valid;
  logic          s2_take;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.color_standard <= ryc_pkg::STD_BT601;
      cfg.studio_range   <= 1'b0;
      cfg.chroma_mode    <= ryc_pkg::CHROMA_420;
      cfg.frame_width    <= ryc_pkg::DIM_W'(640);
      cfg.frame_height   <= ryc_pkg::DIM_W'(480);
    end else if (cfg_write) begin
      unique case (ryc_pkg::cfg_reg_t'(cfg_index))
        ryc_pkg::REG_COLOR_STANDARD: cfg.color_standard <= cfg_data[1:0];
        ryc_pkg::REG_STUDIO_RANGE:   cfg.studio_range   <= cfg_data[0];
        ryc_pkg::REG_CHROMA_MODE:    cfg.chroma_mode    <= cfg_data[0];
        ryc_pkg::REG_FRAME_WIDTH:    cfg.frame_width    <= cfg_data[ryc_pkg::DIM_W-1:0];
        ryc_pkg::REG_FRAME_HEIGHT:   cfg.frame_height   <= cfg_data[ryc_pkg::DIM_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_pix.red   = pix_in.red;
  assign in_pix.green = pix_in.green;
  assign in_pix.blue  = pix_in.blue;

  ryc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (pix_in.valid),
    .in_pix    (in_pix),
    .in_ready  (pix_in.ready),
    .out_valid (s2_valid),
    .out_data  (s2_data),
    .out_take  (s2_take)
  );

  ryc_matrix u_matrix (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (s2_valid),
    .in_data   (s2_data),
    .in_take   (s2_take),
    .out_valid (ycc_out.valid),
    .out_data  (res),
    .out_ready (ycc_out.ready)
  );

  assign ycc_out.luma         = res.luma;
  assign ycc_out.chroma_valid = res.chroma_valid;
  assign ycc_out.blue_diff    = res.blue_diff;
  assign ycc_out.red_diff     = res.red_diff;
  assign ycc_out.frame_last   = res.frame_last;

endmodule

`default_nettype wire

FILE: test/ycbcr_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the RGB to YCbCr converter: predicts every result and checks the output channel.
module ycbcr_checker (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_write,
  input  wire logic [ryc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [ryc_pkg::CFG_DATA_W-1:0]  cfg_data,
  ryc_rgb_if                                   pix,
  ryc_ycc_if                                   ycc,
  output int                                   errors,
  output int                                   pending
);
  import ryc_pkg::*;

  localparam int FRAC = 16;
  localparam int MAX_SHOWN = 40;

  // rows: standard * 2 + studio; columns: Y, Cb, Cr rows of R, G, B weights
  longint coefs [0:5][0:8];

  logic [1:0]        std_code;
  logic              studio;
  logic              mode;
  logic [DIM_W-1:0]  frame_w;
  logic [DIM_W-1:0]  frame_h;

  logic [SUM_W-1:0]  line_r [LINE_DEPTH];
  logic [SUM_W-1:0]  line_g [LINE_DEPTH];
  logic [SUM_W-1:0]  line_b [LINE_DEPTH];
  logic [23:0]       held;
  int                col;
  int                row;

  res_t              expected_ycc [$];
  res_t              want;
  res_t              predicted;

  initial begin
    coefs = '{
      '{19595, 38470, 7471, -11058, -21710, 32768, 32768, -27439, -5329},
      '{16829, 33039, 6416, -9714, -19070, 28784, 28784, -24103, -4681},
      '{13933, 46871, 4732, -7509, -25259, 32768, 32768, -29763, -3005},
      '{11966, 40254, 4064, -6596, -22188, 28784, 28784, -26145, -2639},
      '{17216, 44433, 3887, -9151, -23617, 32768, 32768, -30133, -2635},
      '{14786, 38160, 3340, -8038, -20746, 28784, 28784, -26469, -2315}
    };
  end

  task automatic note_mismatch(input string what, input logic [7:0] got,
                               input logic [7:0] exp_val);
    errors++;
    if (errors <= MAX_SHOWN)
      $display("%0t ns: %s mismatch, got %0h expected %0h", $time, what, got, exp_val);
  endtask

  // Floor shift, then saturate to 0..255; a negative sum always gives 0.
  function automatic logic [7:0] scale_clamp(input longint acc, input int sh);
    longint v;
    v = acc >>> sh;
    if (acc < 0) return 8'd0;
    if (v > 255) return 8'd255;
    return v[7:0];
  endfunction

  // Chroma of a block of 2^lg pixels from its component sums, rounded once.
  task automatic block_chroma(input int set, input longint rs, input longint gs,
                              input longint bs, input int lg,
                              output logic [7:0] cb, output logic [7:0] cr);
    longint bias;
    bias = ((longint'(128) << FRAC) + (longint'(1) << (FRAC - 1))) << lg;
    cb = scale_clamp(coefs[set][3] * rs + coefs[set][4] * gs + coefs[set][5] * bs + bias,
                     FRAC + lg);
    cr = scale_clamp(coefs[set][6] * rs + coefs[set][7] * gs + coefs[set][8] * bs + bias,
                     FRAC + lg);
  endtask

  task automatic convert_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b,
                               output res_t res);
    int          set;
    int          w;
    int          h;
    int          idx;
    int          lg;
    bit          last_col;
    bit          bottom_row;
    bit          odd_col;
    longint      rv;
    longint      gv;
    longint      bv;
    longint      rs;
    longint      gs;
    longint      bs;
    longint      yadd;
    logic [7:0]  cb;
    logic [7:0]  cr;
    rv = r;
    gv = g;
    bv = b;
    set = 2 * int'((std_code > STD_BT2020) ? STD_BT601 : std_code) + int'(studio);
    w = (frame_w < 1) ? 1 : ((frame_w > MAX_WIDTH) ? MAX_WIDTH : int'(frame_w));
    h = (frame_h < 1) ? 1 : ((frame_h > MAX_HEIGHT) ? MAX_HEIGHT : int'(frame_h));
    last_col = (col + 1 >= w);
    bottom_row = (row + 1 >= h);
    yadd = (studio ? (longint'(16) << FRAC) : 0) + (longint'(1) << (FRAC - 1));
    res = '0;
    res.luma = scale_clamp(coefs[set][0] * rv + coefs[set][1] * gv + coefs[set][2] * bv + yadd,
                           FRAC);
    idx = col >> 1;
    if (idx >= LINE_DEPTH) idx = LINE_DEPTH - 1;

    if (mode == CHROMA_444) begin
      block_chroma(set, rv, gv, bv, 0, cb, cr);
      res.chroma_valid = 1'b1;
      res.blue_diff = cb;
      res.red_diff = cr;
    end else if ((col & 1) == 0 && !last_col) begin
      held = {r, g, b};
    end else begin
      odd_col = (col & 1) != 0;
      rs = rv + (odd_col ? longint'(held[23:16]) : 0);
      gs = gv + (odd_col ? longint'(held[15:8]) : 0);
      bs = bv + (odd_col ? longint'(held[7:0]) : 0);
      lg = odd_col ? 1 : 0;
      if ((row & 1) != 0) begin
        block_chroma(set, rs + longint'(line_r[idx]), gs + longint'(line_g[idx]),
                     bs + longint'(line_b[idx]), lg + 1, cb, cr);
        res.chroma_valid = 1'b1;
        res.blue_diff = cb;
        res.red_diff = cr;
      end else if (bottom_row) begin
        block_chroma(set, rs, gs, bs, lg, cb, cr);
        res.chroma_valid = 1'b1;
        res.blue_diff = cb;
        res.red_diff = cr;
      end else begin
        line_r[idx] = rs[SUM_W-1:0];
        line_g[idx] = gs[SUM_W-1:0];
        line_b[idx] = bs[SUM_W-1:0];
      end
    end

    res.frame_last = last_col && bottom_row;
    if (last_col) begin
      col = 0;
      row = bottom_row ? 0 : row + 1;
    end else begin
      col++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      std_code = STD_BT601;
      studio = 1'b0;
      mode = CHROMA_420;
      frame_w = 640;
      frame_h = 480;
      held = '0;
      col = 0;
      row = 0;
      expected_ycc.delete();
    end else begin
      // check the result before queueing this edge's pixel
      if (ycc.valid && ycc.ready) begin
        if (expected_ycc.size() == 0) begin
          note_mismatch("unexpected result, luma", ycc.luma, 8'd0);
        end else begin
          want = expected_ycc.pop_front();
          if (ycc.luma !== want.luma) note_mismatch("luma", ycc.luma, want.luma);
          if (ycc.chroma_valid !== want.chroma_valid)
            note_mismatch("chroma_valid", ycc.chroma_valid, want.chroma_valid);
          if (ycc.blue_diff !== want.blue_diff)
            note_mismatch("blue_diff", ycc.blue_diff, want.blue_diff);
          if (ycc.red_diff !== want.red_diff)
            note_mismatch("red_diff", ycc.red_diff, want.red_diff);
          if (ycc.frame_last !== want.frame_last)
            note_mismatch("frame_last", ycc.frame_last, want.frame_last);
        end
      end
      if (pix.valid && pix.ready) begin
        convert_pixel(pix.red, pix.green, pix.blue, predicted);
        expected_ycc.push_back(predicted);
      end
      if (cfg_write) begin
        case (cfg_index)
          REG_COLOR_STANDARD: std_code = cfg_data[1:0];
          REG_STUDIO_RANGE:   studio = cfg_data[0];
          REG_CHROMA_MODE:    mode = cfg_data[0];
          REG_FRAME_WIDTH:    frame_w = cfg_data;
          REG_FRAME_HEIGHT:   frame_h = cfg_data;
          default: ;
        endcase
      end
    end
    pending <= expected_ycc.size();
  end

endmodule

FILE: test/tb_top.sv
`timescale 1ns / 1ps
// Top-level testbench for the RGB to YCbCr converter: stimulus, flow control and verdict.
module tb_top;
  import ryc_pkg::*;

  localparam logic [1:0] STD_RESERVED = 2'd3;
  localparam int ITEMS       = 1500;
  localparam int SETTLE      = 8;
  localparam int HOLD_CYCLES = 100;
  localparam int LIMIT       = 200000;

  logic                   clk;
  logic                   rst;
  logic                   cfg_write;
  cfg_reg_t               cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  ryc_rgb_if pix_in ();
  ryc_ycc_if ycc_out ();

  int  errors;
  int  pending;
  int  sent;
  int  cycles;
  bit  steady;
  bit  hold_req;
  bit  hold_done;

  pix_t extremes [8] = '{24'h000000, 24'hFFFFFF, 24'hFF0000, 24'h00FF00,
                         24'h0000FF, 24'hFFFF00, 24'h00FFFF, 24'hFF00FF};

  rgb_to_ycbcr_subsampling_converter dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .pix_in    (pix_in),
    .ycc_out   (ycc_out)
  );

  ycbcr_checker chk (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .pix       (pix_in),
    .ycc       (ycc_out),
    .errors    (errors),
    .pending   (pending)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Receiver: random stalls, one long hold-off on request, none in the steady window.
  initial begin
    ycc_out.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        ycc_out.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        ycc_out.ready <= steady || ($urandom_range(99) >= 29);
      end
    end
  end

  task automatic send_pixel(input pix_t px);
    if (!steady && $urandom_range(99) < 29) begin
      pix_in.valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < 29) @(posedge clk);
    end
    pix_in.valid <= 1'b1;
    pix_in.red   <= px.red;
    pix_in.green <= px.green;
    pix_in.blue  <= px.blue;
    @(posedge clk);
    while (!pix_in.ready) @(posedge clk);
    sent++;
    steady = (sent >= 700 && sent < 900);
  endtask

  // Stop offering, wait for every result, then let the pipeline empty.
  task automatic settle();
    pix_in.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic configure(input logic [1:0] std_code, input logic studio, input logic mode,
                           input logic [CFG_DATA_W-1:0] width,
                           input logic [CFG_DATA_W-1:0] height);
    cfg_write <= 1'b1;
    cfg_index <= REG_COLOR_STANDARD;
    cfg_data  <= CFG_DATA_W'(std_code);
    @(posedge clk);
    cfg_index <= REG_STUDIO_RANGE;
    cfg_data  <= CFG_DATA_W'(studio);
    @(posedge clk);
    cfg_index <= REG_CHROMA_MODE;
    cfg_data  <= CFG_DATA_W'(mode);
    @(posedge clk);
    cfg_index <= REG_FRAME_WIDTH;
    cfg_data  <= width;
    @(posedge clk);
    cfg_index <= REG_FRAME_HEIGHT;
    cfg_data  <= height;
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  initial begin
    logic [1:0]            std_code;
    logic                  studio;
    logic                  mode;
    int                    w;
    int                    h;
    int                    frames;
    int                    phase;
    pix_t                  px;

    rst          <= 1'b1;
    cfg_write    <= 1'b0;
    cfg_index    <= REG_COLOR_STANDARD;
    cfg_data     <= '0;
    pix_in.valid <= 1'b0;
    pix_in.red   <= '0;
    pix_in.green <= '0;
    pix_in.blue  <= '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // each standard, the reserved code too, in both ranges; one-pixel frames
    for (int s = 0; s < 4; s++) begin
      for (int st = 0; st < 2; st++) begin
        settle();
        configure(s[1:0], st[0], CHROMA_444, 1, 1);
        send_pixel(extremes[s * 2 + st]);
      end
    end

    // 3x4 frame in 4:2:0 with row 2 switched to 4:4:4
    settle();
    configure(STD_BT601, 1'b0, CHROMA_420, 3, 4);
    for (int i = 0; i < 6; i++) send_pixel(extremes[i]);
    settle();
    configure(STD_BT601, 1'b0, CHROMA_444, 3, 4);
    for (int i = 0; i < 3; i++) send_pixel(extremes[7 - i]);
    settle();
    configure(STD_BT601, 1'b0, CHROMA_420, 3, 4);
    for (int i = 0; i < 3; i++) send_pixel(extremes[i + 3]);

    // widest frame, then shrink width and height under a part-done frame
    settle();
    configure(STD_BT709, 1'b1, CHROMA_420, 4096, 4096);
    for (int i = 0; i < 5; i++) send_pixel(extremes[i + 1]);
    settle();
    configure(STD_BT709, 1'b1, CHROMA_420, 3, 4096);
    for (int i = 0; i < 4; i++) send_pixel(extremes[7 - i]);
    settle();
    configure(STD_BT709, 1'b1, CHROMA_420, 3, 1);
    for (int i = 0; i < 3; i++) send_pixel(extremes[i * 2]);

    // sizes beyond the maximum, then zero sizes closing the frame
    settle();
    configure(STD_BT2020, 1'b0, CHROMA_420, 8191, 8191);
    for (int i = 0; i < 3; i++) send_pixel(extremes[i + 4]);
    settle();
    configure(STD_BT2020, 1'b0, CHROMA_420, 0, 0);
    send_pixel(extremes[1]);

    // random settings, whole frames of random pixels
    phase = 0;
    while (sent < ITEMS) begin
      settle();
      std_code = 2'($urandom_range(3));
      studio = 1'($urandom_range(1));
      mode = 1'($urandom_range(1));
      w = ($urandom_range(9) == 0) ? $urandom_range(13, 80) : $urandom_range(1, 12);
      h = (w > 12) ? $urandom_range(1, 2) : $urandom_range(1, 6);
      frames = $urandom_range(1, 3);
      if (phase == 3) begin
        // long receiver hold-off while this phase keeps offering
        w = 12;
        h = 6;
        hold_req = 1'b1;
      end
      configure(std_code, studio, mode, CFG_DATA_W'(w), CFG_DATA_W'(h));
      repeat (frames * w * h) begin
        px = 24'($urandom);
        if ($urandom_range(9) == 0) px = extremes[$urandom_range(7)];
        send_pixel(px);
      end
      phase++;
    end

    settle();
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

FILE: rgb_to_ycbcr_subsampling_converter.f
rtl/ryc_pkg.sv
rtl/ryc_rgb_if.sv
rtl/ryc_ycc_if.sv
rtl/ryc_ram.sv
rtl/ryc_front.sv
rtl/ryc_matrix.sv
rtl/rgb_to_ycbcr_subsampling_converter.sv
test/ycbcr_checker.sv
test/tb_top.sv
